### hw/rtl/ssw_pkg.sv
package ssw_pkg;

   // Field and register widths
   localparam int STEP_W    = 48;
   localparam int ACC_W     = 49;
   localparam int FRAME_W   = 20;
   localparam int ENV_W     = 25;
   localparam int DUTY_W    = 17;
   localparam int AMP_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   // Shared multiplier: 25 x 25 unsigned, product split at bit 24
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;
   localparam int FRAC_W = 24;
   localparam int MAG_W  = PROD_W + 1 - FRAC_W;

   // Envelope full scale, Q24
   localparam logic [ENV_W-1:0] ENV_FULL = ENV_W'(1) << FRAC_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DELTA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENVELOPE_STEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE     = 3'd5;

   localparam logic [DUTY_W-1:0] DUTY_RESET = 17'd32768;

   // Sequencer to sweep-state commands
   typedef struct packed {
      logic load;      // sample transfer accepted
      logic restart;   // begin a new sweep with this sample
      logic advance;   // step, envelope and index move to the next sample
   } sweep_cmd_type;

   // Sweep-state status toward the sequencer
   typedef struct packed {
      logic             run;    // current sample belongs to a sweep
      logic             last;   // current sample ends the sweep
      logic             high;   // phase below duty level
      logic [ENV_W-1:0] env;    // envelope of the current sample
   } sweep_stat_type;

endpackage

### hw/rtl/ssw_mult.sv
module ssw_mult
   import ssw_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   // Unsigned multiply, registered
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

### hw/rtl/ssw_sweep.sv
module ssw_sweep
   import ssw_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  sweep_cmd_type       cmd,
   input  logic [STEP_W-1:0]   start_step,
   input  logic [STEP_W-1:0]   step_delta,
   input  logic [FRAME_W-1:0]  frame_count,
   input  logic [ENV_W-1:0]    envelope_step,
   input  logic [DUTY_W-1:0]   duty_level,
   output sweep_stat_type      stat
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in, phase_base;
   logic [ACC_W-1:0]      step_ff, step_in, step_base;
   logic [ENV_W-1:0]      env_ff, env_in;
   logic [FRAME_W-1:0]    index_ff, index_in;
   logic                  running_ff, running_in;
   logic                  run_now;
   logic [PHASE_BITS:0]   duty_scaled;
   logic [FRAME_W:0]      index_next;

   // Sample start: restart reloads, then the phase takes the current step
   assign phase_base = cmd.restart ? '0 : phase_ff;
   assign step_base  = cmd.restart ? {1'b0, start_step} : step_ff;
   assign run_now    = cmd.restart ? (frame_count != '0) : running_ff;

   assign index_next  = {1'b0, index_ff} + (FRAME_W + 1)'(1);
   assign duty_scaled = (PHASE_BITS + 1)'(duty_level) << (PHASE_BITS - 16);

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      env_in     = env_ff;
      index_in   = index_ff;
      running_in = running_ff;
      if (cmd.load) begin
         phase_in   = run_now ? phase_base + step_base[STEP_W-1 -: PHASE_BITS] : phase_base;
         step_in    = step_base;
         env_in     = cmd.restart ? ENV_FULL : env_ff;
         index_in   = cmd.restart ? '0 : index_ff;
         running_in = run_now;
      end else if (cmd.advance) begin
         step_in    = step_ff + {step_delta[STEP_W-1], step_delta};
         env_in     = (env_ff > envelope_step) ? env_ff - envelope_step : '0;
         index_in   = index_next[FRAME_W-1:0];
         running_in = running_ff & ~stat.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         step_ff    <= '0;
         env_ff     <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         env_ff     <= env_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   // Status of the sample in flight
   assign stat.run  = running_ff;
   assign stat.last = index_next >= {1'b0, frame_count};
   assign stat.high = {1'b0, phase_ff} < duty_scaled;
   assign stat.env  = env_ff;

endmodule

### hw/rtl/ssw_shape.sv
module ssw_shape
   import ssw_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic [MAG_W-1:0]       mag_raw,
   input  logic                   high,
   input  logic                   run,
   output logic [SAMPLE_BITS-1:0] sample
);

   localparam logic [MAG_W-1:0] MAX_MAG = (MAG_W'(1) << (SAMPLE_BITS - 1)) - MAG_W'(1);

   logic [MAG_W-1:0]       mag_clip;
   logic [SAMPLE_BITS-1:0] mag;

   // Clamp to full scale, then apply sign of the square wave
   assign mag_clip = (mag_raw > MAX_MAG) ? MAX_MAG : mag_raw;
   assign mag      = mag_clip[SAMPLE_BITS-1:0];

   always_comb begin
      if (!run) begin
         sample = '0;
      end else if (high) begin
         sample = mag;
      end else begin
         sample = '0 - mag;
      end
   end

endmodule

### hw/rtl/square_sweep_tone_generator_core.sv
// Channel  | Dir | Signals                        | Content
// ---------+-----+--------------------------------+---------------------------------------
// req      | in  | req_tvalid/tready/tdata[7:0]   | tdata: [0] restart, rest zero
// rsp      | out | rsp_tvalid/tready/tdata/tuser  | tdata: sample (low SAMPLE_BITS);
//          |     | rsp_tlast                      | tuser: active; tlast: last of sweep
// csr      | in  | csr_we/csr_index/csr_wdata     | register write, no read-back
//
// Each sample goes through these steps: accept, then three passes through the shared
// 25x25 multiplier (envelope squared, low half times amplitude, high half
// times amplitude) and a final step to combine, clamp and load the output register.
// req_tready is high only while the sequencer is idle; a waiting result in the
// output register does not block the next transfer, only the next load.
// Reset is synchronous; it clears the sweep state and restores register defaults.
module square_sweep_tone_generator_core
   import ssw_pkg::*;
#(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // [0] restart
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,
   // [SAMPLE_BITS-1:0] sample, zero fill above
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   // [0] active
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CSR_DAT_W-1:0]                 csr_wdata
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQR  = 3'd1;
   localparam logic [2:0] ST_LOW  = 3'd2;
   localparam logic [2:0] ST_HIGH = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [STEP_W-1:0]  start_step_ff;
   logic [STEP_W-1:0]  step_delta_ff;
   logic [FRAME_W-1:0] frame_count_ff;
   logic [ENV_W-1:0]   envelope_step_ff;
   logic [DUTY_W-1:0]  duty_level_ff;
   logic [AMP_W-1:0]   amplitude_ff;

   logic [2:0]             state_ff, state_in;
   logic [MUL_W-1:0]       hi_ff;
   logic [AMP_W-1:0]       lo_part_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_active_ff;
   logic                   rsp_last_ff;

   logic                   req_xfer;
   logic                   emit;
   logic                   mul_en;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W:0]        mag_sum;
   logic [MAG_W-1:0]       mag_raw;
   logic [SAMPLE_BITS-1:0] sample;
   sweep_cmd_type          cmd;
   sweep_stat_type         stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff    <= '0;
         step_delta_ff    <= '0;
         frame_count_ff   <= '0;
         envelope_step_ff <= '0;
         duty_level_ff    <= DUTY_RESET;
         amplitude_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_STEP:    start_step_ff    <= csr_wdata[STEP_W-1:0];
            REG_STEP_DELTA:    step_delta_ff    <= csr_wdata[STEP_W-1:0];
            REG_FRAME_COUNT:   frame_count_ff   <= csr_wdata[FRAME_W-1:0];
            REG_ENVELOPE_STEP: envelope_step_ff <= csr_wdata[ENV_W-1:0];
            REG_DUTY_LEVEL:    duty_level_ff    <= csr_wdata[DUTY_W-1:0];
            REG_AMPLITUDE:     amplitude_ff     <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign emit       = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_tready);

   assign cmd.load    = req_xfer;
   assign cmd.restart = req_tdata[0];
   assign cmd.advance = emit & stat.run;

   ssw_sweep #(
      .PHASE_BITS (PHASE_BITS)
   ) u_sweep (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .start_step    (start_step_ff),
      .step_delta    (step_delta_ff),
      .frame_count   (frame_count_ff),
      .envelope_step (envelope_step_ff),
      .duty_level    (duty_level_ff),
      .stat          (stat)
   );

   // Sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_xfer ? ST_SQR : ST_IDLE;
         ST_SQR:  state_in = ST_LOW;
         ST_LOW:  state_in = ST_HIGH;
         ST_HIGH: state_in = ST_DONE;
         ST_DONE: state_in = emit ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      case (state_ff)
         ST_SQR: begin
            mul_a = stat.env;
            mul_b = stat.env;
         end
         ST_LOW: begin
            mul_a = MUL_W'(prod_ff[FRAC_W-1:0]);
            mul_b = MUL_W'(amplitude_ff);
         end
         ST_HIGH: begin
            mul_a = hi_ff;
            mul_b = MUL_W'(amplitude_ff);
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = stat.env;
            mul_b  = stat.env;
         end
      endcase
   end

   ssw_mult u_mult (
      .clock   (clock),
      .en      (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   // Partial products held between passes
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOW) begin
         hi_ff <= prod_ff[FRAC_W +: MUL_W];
      end
      if (state_ff == ST_HIGH) begin
         lo_part_ff <= prod_ff[FRAC_W +: AMP_W];
      end
   end

   // env^2 * amp / 2^48 = (hi * amp + (lo * amp >> 24)) >> 24
   assign mag_sum = {1'b0, prod_ff} + (PROD_W + 1)'(lo_part_ff);
   assign mag_raw = mag_sum[PROD_W:FRAC_W];

   ssw_shape #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_shape (
      .mag_raw (mag_raw),
      .high    (stat.high),
      .run     (stat.run),
      .sample  (sample)
   );

   // Output register
   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sample_ff <= sample;
         rsp_active_ff <= stat.run;
         rsp_last_ff   <= stat.run & stat.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_sample_ff);
   assign rsp_tuser  = rsp_active_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SQR))
      else $error("accepted sample did not start the multiply sequence");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_active_ff) |-> (rsp_sample_ff == '0))
      else $error("idle sample is not zero");

   a_last_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_active_ff)
      else $error("last marked on an inactive sample");

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQR) |-> (stat.env <= ENV_FULL))
      else $error("envelope above full scale");

endmodule
